// ===== rtl/ufe_pkg.sv =====
// Shared types and constants for the union-find engine.
// Depends on nothing.
package ufe_pkg;
   localparam int IDX_W  = 10;
   localparam int SIZE_W = 11;

   localparam logic REQ_FIND  = 1'b0;
   localparam logic REQ_UNION = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [IDX_W-1:0]  node_a;
      logic [IDX_W-1:0]  node_b;
      logic              err;
   } cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0]  root;
      logic [SIZE_W-1:0] set_size;
      logic              already_joined;
      logic              range_error;
   } rsp_type;
endpackage

// ===== rtl/ufe_front.sv =====
// Front end: accepts requests, range-checks them and queues commands.
// Depends on ufe_pkg.
module ufe_front #(
   parameter int NODES = 1024,
   parameter int QDEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [ufe_pkg::IDX_W-1:0] node_limit,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_type,
   input  logic [ufe_pkg::IDX_W-1:0] req_node_a,
   input  logic [ufe_pkg::IDX_W-1:0] req_node_b,
   output logic                    cmd_valid,
   input  logic                    cmd_ready,
   output ufe_pkg::cmd_type        cmd
);
   import ufe_pkg::*;

   cmd_type q_ff [QDEPTH];
   logic [$clog2(QDEPTH)-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [$clog2(QDEPTH):0]   cnt_ff, cnt_in;
   cmd_type nc;
   logic push, pop;

   function automatic logic bad(input logic [IDX_W-1:0] n, input logic [IDX_W-1:0] lim);
      return (n > lim) || (32'(n) >= NODES);
   endfunction

   always_comb begin
      nc.kind   = req_type;
      nc.node_a = req_node_a;
      nc.node_b = req_node_b;
      nc.err    = bad(req_node_a, node_limit) ||
                  ((req_type == REQ_UNION) && bad(req_node_b, node_limit));
      req_ready = (32'(cnt_ff) < QDEPTH);
      cmd_valid = (cnt_ff != '0);
      cmd       = q_ff[rp_ff];
      push      = req_valid && req_ready;
      pop       = cmd_valid && cmd_ready;
      wp_in     = push ? ((32'(wp_ff) == QDEPTH-1) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in     = pop ? ((32'(rp_ff) == QDEPTH-1) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in    = cnt_ff + {{$clog2(QDEPTH){1'b0}}, push} - {{$clog2(QDEPTH){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= nc;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== rtl/ufe_back.sv =====
// Back end: walks the parent store, compresses paths and merges sets.
// Depends on ufe_pkg. Holds the parent and size memories.
module ufe_back #(
   parameter int NODES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  ufe_pkg::cmd_type cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output ufe_pkg::rsp_type out
);
   import ufe_pkg::*;
   localparam int AW = $clog2(NODES);

   typedef enum logic [9:0] {
      S_CLR   = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_RD    = 10'b0000000100,
      S_WALK  = 10'b0000001000,
      S_CRD   = 10'b0000010000,
      S_CMP   = 10'b0000100000,
      S_SZRD  = 10'b0001000000,
      S_SZ    = 10'b0010000000,
      S_MRG   = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type st_ff;
   logic [IDX_W-1:0] par_mem [NODES];
   logic [SIZE_W-1:0] siz_mem [NODES];
   logic [IDX_W-1:0] prd_ff;
   logic [SIZE_W-1:0] srd_ff;
   logic [AW:0] clr_ff;
   logic [AW:0] steps_ff;
   cmd_type c_ff;
   logic phase_ff;                    // 0: node_a, 1: node_b
   logic [IDX_W-1:0] cur_ff, ra_ff, rt_ff;
   logic [SIZE_W-1:0] sa_ff;
   rsp_type r_ff;

   logic p_we, s_we;
   logic [AW-1:0] p_wa, s_wa, p_ra, s_ra;
   logic [IDX_W-1:0] p_wd;
   logic [SIZE_W-1:0] s_wd;

   function automatic logic [AW-1:0] ix(input logic [IDX_W-1:0] v);
      return AW'(v);
   endfunction

   logic p_oob, p_self;
   assign p_oob  = 32'(prd_ff) >= NODES;
   assign p_self = prd_ff == cur_ff;

   always_comb begin
      p_we = 1'b0; s_we = 1'b0;
      p_wa = ix(cur_ff); s_wa = ix(cur_ff);
      p_wd = rt_ff; s_wd = '0;
      p_ra = ix(cur_ff); s_ra = ix(rt_ff);
      unique case (st_ff)
         S_CLR: begin
            p_we = 1'b1; s_we = 1'b1;
            p_wa = clr_ff[AW-1:0]; s_wa = clr_ff[AW-1:0];
            p_wd = IDX_W'(clr_ff[AW-1:0]); s_wd = SIZE_W'(1);
         end
         S_WALK: p_ra = (p_oob || p_self) ? ix(cur_ff) : ix(prd_ff);
         S_CMP:  p_we = (cur_ff != rt_ff);
         S_CRD:  p_ra = ix(cur_ff);
         S_SZ:   s_ra = ix(ra_ff);
         S_MRG: begin
            p_we = !r_ff.already_joined;
            s_we = !r_ff.already_joined;
            if (srd_ff <= sa_ff) begin
               p_wa = ix(rt_ff); p_wd = ra_ff;
               s_wa = ix(ra_ff);
            end else begin
               p_wa = ix(ra_ff); p_wd = rt_ff;
               s_wa = ix(rt_ff);
            end
            s_wd = sa_ff + srd_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (p_we) par_mem[p_wa] <= p_wd;
      if (s_we) siz_mem[s_wa] <= s_wd;
      prd_ff <= par_mem[p_ra];
      srd_ff <= siz_mem[s_ra];
   end

   assign cmd_ready = (st_ff == S_IDLE);
   assign out_valid = (st_ff == S_OUT);
   assign out       = r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_CLR;
         clr_ff <= '0;
      end else begin
         unique case (st_ff)
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == NODES-1) st_ff <= S_IDLE;
            end
            S_IDLE: if (cmd_valid) begin
               c_ff <= cmd;
               r_ff <= '0;
               phase_ff <= 1'b0;
               cur_ff <= cmd.node_a;
               steps_ff <= '0;
               if (cmd.err) begin
                  r_ff.range_error <= 1'b1;
                  st_ff <= S_OUT;
               end else st_ff <= S_RD;
            end
            S_RD: st_ff <= S_WALK;
            S_WALK: begin
               if (p_oob || p_self || 32'(steps_ff) == NODES-1) begin
                  rt_ff <= cur_ff;
                  cur_ff <= phase_ff ? c_ff.node_b : c_ff.node_a;
                  steps_ff <= '0;
                  st_ff <= S_CRD;
               end else begin
                  cur_ff <= prd_ff;
                  steps_ff <= steps_ff + 1'b1;
               end
            end
            S_CRD: st_ff <= S_CMP;
            S_CMP: begin
               if (cur_ff == rt_ff || p_oob || 32'(steps_ff) == NODES-1) begin
                  if (c_ff.kind == REQ_UNION && !phase_ff) begin
                     ra_ff <= rt_ff;
                     phase_ff <= 1'b1;
                     cur_ff <= c_ff.node_b;
                     steps_ff <= '0;
                     st_ff <= S_RD;
                  end else st_ff <= S_SZRD;
               end else begin
                  cur_ff <= prd_ff;
                  steps_ff <= steps_ff + 1'b1;
                  st_ff <= S_CRD;
               end
            end
            S_SZRD: begin
               // size of current root now being read (s_ra = rt_ff)
               st_ff <= S_SZ;
            end
            S_SZ: begin
               if (c_ff.kind == REQ_FIND) begin
                  r_ff.root <= rt_ff;
                  r_ff.set_size <= srd_ff;
                  st_ff <= S_OUT;
               end else if (ra_ff == rt_ff) begin
                  r_ff.root <= rt_ff;
                  r_ff.set_size <= srd_ff;
                  r_ff.already_joined <= 1'b1;
                  st_ff <= S_OUT;
               end else begin
                  // srd_ff = size(rb); fetch size(ra) next
                  sa_ff <= srd_ff;
                  {ra_ff, rt_ff} <= {rt_ff, ra_ff};
                  st_ff <= S_MRG;
               end
            end
            S_MRG: begin
               // after swap: ra_ff=rb, rt_ff=ra, sa_ff=size(rb), srd_ff=size(ra)
               r_ff.set_size <= sa_ff + srd_ff;
               r_ff.root <= (srd_ff <= sa_ff) ? ra_ff : rt_ff;
               st_ff <= S_OUT;
            end
            S_OUT: if (out_ready) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/union_find_engine.sv =====
// Union-find engine top level: front end, command queue and back end.
// One request is in the back end at a time; a new one is taken only after the
// previous result is transferred, and a range error goes straight to the response.
// The queue holds two requests. Reset: synchronous; a clearing pass fills both
// stores while up to two requests wait in the queue; node_limit resets to 1023.
// Depends on ufe_pkg, ufe_front, ufe_back.
module union_find_engine #(
   parameter int NODES = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [ufe_pkg::IDX_W-1:0] csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic [ufe_pkg::IDX_W-1:0] req_node_a,
   input  logic [ufe_pkg::IDX_W-1:0] req_node_b,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [ufe_pkg::IDX_W-1:0] rsp_root,
   output logic [ufe_pkg::SIZE_W-1:0] rsp_set_size,
   output logic                      rsp_already_joined,
   output logic                      rsp_range_error
);
   import ufe_pkg::*;

   logic [IDX_W-1:0] limit_ff;
   logic cmd_valid, cmd_ready;
   cmd_type cmd;
   rsp_type r;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= 10'd1023;
      else if (csr_we) limit_ff <= csr_wdata;
   end

   ufe_front #(.NODES(NODES)) u_front (
      .clock, .reset, .node_limit(limit_ff),
      .req_valid, .req_ready, .req_type, .req_node_a, .req_node_b,
      .cmd_valid, .cmd_ready, .cmd
   );

   ufe_back #(.NODES(NODES)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out(r)
   );

   assign rsp_root           = r.root;
   assign rsp_set_size       = r.set_size;
   assign rsp_already_joined = r.already_joined;
   assign rsp_range_error    = r.range_error;
endmodule

// ===== rtl/ufe_checker.sv =====
// Port-level checker for the union-find engine, bound to the top level.
// Depends on ufe_pkg.
module ufe_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [ufe_pkg::IDX_W-1:0] rsp_root,
   input logic [ufe_pkg::SIZE_W-1:0] rsp_set_size,
   input logic                      rsp_already_joined,
   input logic                      rsp_range_error
);
   import ufe_pkg::*;

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |->
         rsp_root == '0 && rsp_set_size == '0 && !rsp_already_joined)
      else $error("error response carries data");

   a_size_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_range_error |-> rsp_set_size != '0)
      else $error("zero set size");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_root))
      else $error("response dropped");

   a_rst_ready: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad handshake state after reset");
endmodule

bind union_find_engine ufe_checker u_chk (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for union_find_engine: directed and random find/union traffic.
// A disjoint-set predictor in the testbench checks every response; depends on ufe_pkg and the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ufe_pkg::*;

   localparam int NODES = 1024;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [IDX_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = REQ_FIND;
   logic [IDX_W-1:0] req_node_a = '0;
   logic [IDX_W-1:0] req_node_b = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [IDX_W-1:0] rsp_root;
   logic [SIZE_W-1:0] rsp_set_size;
   logic rsp_already_joined;
   logic rsp_range_error;

   union_find_engine #(.NODES(NODES)) i_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_node_a(req_node_a), .req_node_b(req_node_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_root(rsp_root),
      .rsp_set_size(rsp_set_size), .rsp_already_joined(rsp_already_joined),
      .rsp_range_error(rsp_range_error)
   );

   always #6 clock = ~clock;

   logic [IDX_W-1:0] model_parent [NODES];
   logic [SIZE_W-1:0] model_size [NODES];
   logic [IDX_W-1:0] model_limit;
   rsp_type pending_rsp [$];
   int errors = 0;
   int cycles = 0;
   int hold_cycles = 0;
   bit rsp_random = 1'b1;
   int short_range = 1024;

   function automatic logic [IDX_W-1:0] find_root(input logic [IDX_W-1:0] node);
      logic [IDX_W-1:0] cur;
      logic [IDX_W-1:0] nxt;
      logic [IDX_W-1:0] top;
      cur = node;
      for (int i = 0; i < NODES; i++) begin
         if (model_parent[cur] == cur) break;
         cur = model_parent[cur];
      end
      top = cur;
      cur = node;
      for (int i = 0; i < NODES && cur != top; i++) begin
         nxt = model_parent[cur];
         model_parent[cur] = top;
         cur = nxt;
      end
      return top;
   endfunction

   function automatic rsp_type predict_rsp(input logic kind, input logic [IDX_W-1:0] a,
                                           input logic [IDX_W-1:0] b);
      rsp_type r;
      logic [IDX_W-1:0] ra;
      logic [IDX_W-1:0] rb;
      r = '0;
      if (a > model_limit || (kind == REQ_UNION && b > model_limit)) begin
         r.range_error = 1'b1;
      end else if (kind == REQ_FIND) begin
         r.root = find_root(a);
         r.set_size = model_size[r.root];
      end else begin
         ra = find_root(a);
         rb = find_root(b);
         if (ra == rb) begin
            r.already_joined = 1'b1;
            r.root = ra;
         end else if (model_size[ra] <= model_size[rb]) begin
            model_parent[ra] = rb;
            model_size[rb] = model_size[rb] + model_size[ra];
            r.root = rb;
         end else begin
            model_parent[rb] = ra;
            model_size[ra] = model_size[ra] + model_size[rb];
            r.root = ra;
         end
         r.set_size = model_size[r.root];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("union_find_engine: mismatch");
         $finish;
      end
   end

   // check each result transfer against the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%t unexpected rsp root %0d size %0d", $time, rsp_root, rsp_set_size);
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_root !== exp_rsp.root) begin
               errors++;
               $display("%t root exp %0d got %0d", $time, exp_rsp.root, rsp_root);
            end
            if (rsp_set_size !== exp_rsp.set_size) begin
               errors++;
               $display("%t set_size exp %0d got %0d", $time, exp_rsp.set_size, rsp_set_size);
            end
            if (rsp_already_joined !== exp_rsp.already_joined) begin
               errors++;
               $display("%t already_joined exp %0d got %0d", $time,
                        exp_rsp.already_joined, rsp_already_joined);
            end
            if (rsp_range_error !== exp_rsp.range_error) begin
               errors++;
               $display("%t range_error exp %0d got %0d", $time,
                        exp_rsp.range_error, rsp_range_error);
            end
         end
      end
   end

   // receiver: random stalls per transfer, a long hold-off on request, or always ready
   initial begin
      int wait_n;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else if (!rsp_random) begin
            rsp_ready <= 1'b1;
         end else if (rsp_ready && !rsp_valid) begin
            rsp_ready <= 1'b1;
         end else begin
            wait_n = $urandom_range(0, 7);
            if (wait_n == 0 || $urandom_range(0, 3) == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (wait_n) @(negedge clock);
               rsp_ready <= 1'b1;
            end
            while (!(rsp_valid && rsp_ready)) @(negedge clock);
         end
      end
   end

   task automatic send_req(input logic kind, input logic [IDX_W-1:0] a,
                           input logic [IDX_W-1:0] b, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_node_a <= a;
      req_node_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(predict_rsp(kind, a, b));
      @(negedge clock);
   endtask

   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_limit(input logic [IDX_W-1:0] value);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      model_limit = value;
   endtask

   task automatic test_directed();
      send_req(REQ_FIND, 10'd0, 10'd0, 0);
      send_req(REQ_FIND, 10'd1023, 10'd1023, 0);
      send_req(REQ_UNION, 10'd5, 10'd5, 0);
      send_req(REQ_UNION, 10'd0, 10'd1023, 1);
      send_req(REQ_UNION, 10'd1, 10'd2, 0);
      send_req(REQ_UNION, 10'd2, 10'd3, 0);
      send_req(REQ_UNION, 10'd0, 10'd1, 2);
      send_req(REQ_UNION, 10'd1023, 10'd3, 0);
      send_req(REQ_FIND, 10'd0, 10'd1023, 0);
      send_req(REQ_FIND, 10'd682, 10'd341, 0);
      send_req(REQ_UNION, 10'd341, 10'd682, 0);
      write_limit(10'd0);
      send_req(REQ_FIND, 10'd0, 10'd1023, 0);
      send_req(REQ_FIND, 10'd1, 10'd0, 0);
      send_req(REQ_UNION, 10'd0, 10'd1, 0);
      send_req(REQ_UNION, 10'd0, 10'd0, 0);
      write_limit(10'd3);
      send_req(REQ_FIND, 10'd2, 10'd0, 0);
      send_req(REQ_UNION, 10'd4, 10'd2, 0);
      send_req(REQ_UNION, 10'd3, 10'd1, 0);
      drain();
   endtask

   task automatic test_random(input logic [IDX_W-1:0] limit, input int count);
      logic kind;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      write_limit(limit);
      for (int i = 0; i < count; i++) begin
         kind = ($urandom_range(0, 99) < 55) ? REQ_UNION : REQ_FIND;
         if ($urandom_range(0, 15) == 0) begin
            a = IDX_W'($urandom);
            b = IDX_W'($urandom);
         end else begin
            a = IDX_W'($urandom_range(0, short_range - 1));
            b = IDX_W'($urandom_range(0, short_range - 1));
         end
         send_req(kind, a, b, ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 7)));
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      for (int i = 0; i < 20; i++)
         send_req(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 63)),
                  IDX_W'($urandom_range(0, 63)), 0);
      drain();
      rsp_random = 1'b0;
      for (int i = 0; i < 30; i++)
         send_req(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 63)),
                  IDX_W'($urandom_range(0, 63)), 0);
      drain();
      rsp_random = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < NODES; i++) begin
         model_parent[i] = IDX_W'(i);
         model_size[i] = SIZE_W'(1);
      end
      model_limit = 10'd1023;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      short_range = 64;
      test_random(10'd1023, 300);
      short_range = 1024;
      test_random(10'd1023, 300);
      short_range = 128;
      test_random(10'd100, 200);
      test_random(10'd1, 60);
      short_range = 1024;
      test_random(10'd1023, 120);
      drain();
      if (errors == 0) begin
         $display("union_find_engine: match");
      end else begin
         $display("union_find_engine: mismatch");
      end
      $finish;
   end
endmodule
